### design/sjf_pkg.sv
// Package for the shortest-job-first selector: field widths, opcodes,
// status codes and the result record shared by the controller and top level.
// No dependencies.
package sjf_pkg;

  // Field widths of the transaction payloads.
  localparam int ID_W    = 16;
  localparam int PRIO_W  = 8;
  localparam int BURST_W = 16;

  // Default number of task slots.
  localparam int SJF_TABLE_DEPTH = 16;

  // First task id after reset and after wrapping.
  localparam logic [ID_W-1:0] FIRST_ID = 16'd1;

  // Request opcodes.
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  // One result record as produced by the controller.
  typedef struct packed {
    status_t              status;
    logic [ID_W-1:0]      task_id;
    logic [PRIO_W-1:0]    prio;
    logic [BURST_W-1:0]   burst;
  } sjf_result_t;

endpackage

### design/sjf_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on sjf_pkg for the field widths.
interface sjf_req_if import sjf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [PRIO_W-1:0]    task_priority;
  logic [BURST_W-1:0]   task_burst;

  modport source (output valid, opcode, task_priority, task_burst, input ready);
  modport sink   (input valid, opcode, task_priority, task_burst, output ready);
endinterface

interface sjf_rsp_if import sjf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ID_W-1:0]      out_task_id;
  logic [PRIO_W-1:0]    out_priority;
  logic [BURST_W-1:0]   out_burst;

  modport source (output valid, status, out_task_id, out_priority, out_burst, input ready);
  modport sink   (input valid, status, out_task_id, out_priority, out_burst, output ready);
endinterface

### design/sjf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sjf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/sjf_ctrl.sv
// Sweep controller of the shortest-job-first selector: valid bits, entry count,
// id counter and the read-modify-write sweeps over the task RAM.
// Depends on sjf_pkg, sjf_if (request channel) and an external sjf_ram.
module sjf_ctrl import sjf_pkg::*; #(
  parameter int TABLE_DEPTH = SJF_TABLE_DEPTH,
  parameter int IDX_W       = $clog2(TABLE_DEPTH),
  parameter int WORD_W      = ID_W + PRIO_W + BURST_W + IDX_W
) (
  input  logic              clk,
  input  logic              rst,
  sjf_req_if.sink           req,
  // Task RAM ports.
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [IDX_W-1:0]  ram_raddr,
  input  logic [WORD_W-1:0] ram_rdata,
  // Result hand-off to the output register.
  output logic              res_valid,
  input  logic              res_ready,
  output sjf_result_t       res,
  output logic [IDX_W:0]    entry_count
);

  localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(TABLE_DEPTH);

  typedef enum logic [1:0] {IDLE, SCAN, FIX, FINISH} state_t;

  state_t                 state;
  logic                   op;
  logic [PRIO_W-1:0]      new_prio;
  logic [BURST_W-1:0]     new_burst;
  logic [IDX_W:0]         rd_idx;
  logic                   pend;
  logic [IDX_W-1:0]       pend_idx;
  logic [TABLE_DEPTH-1:0] valid_bits;
  logic [IDX_W:0]         count;
  logic [ID_W-1:0]        next_id;
  logic [ID_W-1:0]        next_id_next;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   best_found;
  logic [IDX_W-1:0]       best_idx;
  logic [ID_W-1:0]        best_id;
  logic [PRIO_W-1:0]      best_prio;
  logic [BURST_W-1:0]     best_burst;
  logic [IDX_W-1:0]       best_age;

  logic                   issue;
  logic                   sweep_done;
  logic                   pend_live;
  logic                   better;
  logic [IDX_W-1:0]       rd_age;
  logic [BURST_W-1:0]     rd_burst;
  logic [PRIO_W-1:0]      rd_prio;
  logic [ID_W-1:0]        rd_id;

  // Entry word layout: {id, priority, burst, age}.
  assign rd_age   = ram_rdata[IDX_W-1:0];
  assign rd_burst = ram_rdata[IDX_W +: BURST_W];
  assign rd_prio  = ram_rdata[IDX_W + BURST_W +: PRIO_W];
  assign rd_id    = ram_rdata[IDX_W + BURST_W + PRIO_W +: ID_W];

  // Sweep address generation: one read per cycle, data returns in the next cycle.
  assign issue      = ((state == SCAN) || (state == FIX)) && (rd_idx != DEPTH_C);
  assign sweep_done = (rd_idx == DEPTH_C) && !pend;
  assign pend_live  = pend && valid_bits[pend_idx];
  assign ram_re     = issue;
  assign ram_raddr  = rd_idx[IDX_W-1:0];

  // Smaller burst wins; on equal bursts the younger entry wins.
  assign better = !best_found || (rd_burst < best_burst) ||
                  ((rd_burst == best_burst) && (rd_age < best_age));

  assign next_id_next = (next_id == '1) ? FIRST_ID : next_id + 1'b1;

  assign req.ready   = (state == IDLE);
  assign res_valid   = (state == FINISH);
  assign entry_count = count;

  // Write-back of the entry read last cycle. The read runs one entry ahead of
  // the write, so the two never touch the same entry and need no forwarding.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_idx;
    ram_wdata = ram_rdata;
    unique case (state)
      SCAN: begin
        if (op == OP_ADD && pend_live) begin
          ram_we    = 1'b1;
          ram_wdata = {ram_rdata[WORD_W-1:IDX_W], rd_age + 1'b1};
        end else if (op == OP_ADD && sweep_done) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = {next_id, new_prio, new_burst, {IDX_W{1'b0}}};
        end
      end
      FIX: begin
        if (pend_live && rd_age > best_age) begin
          ram_we    = 1'b1;
          ram_wdata = {ram_rdata[WORD_W-1:IDX_W], rd_age - 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, table bookkeeping and the result record.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      pend       <= 1'b0;
      valid_bits <= '0;
      count      <= '0;
      next_id    <= FIRST_ID;
    end else begin
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            op         <= req.opcode;
            new_prio   <= req.task_priority;
            new_burst  <= req.task_burst;
            rd_idx     <= '0;
            pend       <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            if (req.opcode == OP_ADD && count == DEPTH_C) begin
              res   <= '{status: ST_FULL, default: '0};
              state <= FINISH;
            end else if (req.opcode == OP_DISPATCH && count == '0) begin
              res   <= '{status: ST_EMPTY, default: '0};
              state <= FINISH;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          pend     <= issue;
          pend_idx <= rd_idx[IDX_W-1:0];
          // Add: remember the lowest free slot. Dispatch: track the best entry.
          if (pend && op == OP_ADD && !free_found && !valid_bits[pend_idx]) begin
            free_found <= 1'b1;
            free_idx   <= pend_idx;
          end
          if (pend_live && op == OP_DISPATCH && better) begin
            best_found <= 1'b1;
            best_idx   <= pend_idx;
            best_id    <= rd_id;
            best_prio  <= rd_prio;
            best_burst <= rd_burst;
            best_age   <= rd_age;
          end
          if (sweep_done) begin
            if (op == OP_ADD) begin
              valid_bits[free_idx] <= 1'b1;
              count   <= count + 1'b1;
              next_id <= next_id_next;
              res     <= '{status: ST_ADDED, task_id: next_id, default: '0};
              state   <= FINISH;
            end else begin
              valid_bits[best_idx] <= 1'b0;
              count  <= count - 1'b1;
              res    <= '{status: ST_DISPATCHED, task_id: best_id,
                          prio: best_prio, burst: best_burst};
              rd_idx <= '0;
              state  <= FIX;
            end
          end
        end
        FIX: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          pend     <= issue;
          pend_idx <= rd_idx[IDX_W-1:0];
          if (sweep_done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### design/shortest_job_first_selector.sv
// Top level of the shortest-job-first selector: task RAM, sweep controller
// and response register. Depends on sjf_pkg, sjf_if, sjf_ram and sjf_ctrl.
//
// The block keeps up to TABLE_DEPTH pending tasks in one RAM entry each, with
// a valid bit per slot in flip-flops. It works on one request transaction at a
// time. An add sweeps the table once, one entry per cycle, to age the stored
// tasks and find the lowest free slot, then writes the new task. A dispatch
// sweeps once to find the smallest burst (ties to the most recently added
// task) and a second time to close the age gap left by the removed task. An
// add into a full table or a dispatch from an empty one answers without a
// sweep. The next request is taken after the response is loaded. The response
// sits in an output register, so a new request is taken while a response still
// waits.
module shortest_job_first_selector import sjf_pkg::*; #(
  parameter int TABLE_DEPTH = SJF_TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  sjf_req_if.sink   req,
  sjf_rsp_if.source rsp
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int WORD_W = ID_W + PRIO_W + BURST_W + IDX_W;
  localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(TABLE_DEPTH);

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              res_valid;
  logic              res_ready;
  sjf_result_t       res;
  logic [IDX_W:0]    entry_count;
  logic              out_valid;
  sjf_result_t       out_res;

  sjf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sjf_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .WORD_W      (WORD_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .entry_count (entry_count)
  );

  // Response register: loads when empty or when its transaction completes.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
        out_res   <= res;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_res.status;
  assign rsp.out_task_id  = out_res.task_id;
  assign rsp.out_priority = out_res.prio;
  assign rsp.out_burst    = out_res.burst;

  // The entry count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= DEPTH_C)
    else $error("entry count exceeds table depth");

  // Only a dispatched task carries a priority and a burst.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_DISPATCHED |-> rsp.out_priority == '0 && rsp.out_burst == '0)
    else $error("non-dispatch response carries task fields");

  // An added task never gets id zero.
  a_nonzero_id: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_ADDED |-> rsp.out_task_id != '0)
    else $error("added task got id zero");

  // After a request transaction the block is not ready again in the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while previous one in progress");

endmodule

### tb/tb.sv
// Self-checking testbench for the shortest-job-first selector.
// It drives add and dispatch transactions with random gaps and checks every response.
// Depends on sjf_pkg, sjf_if and the shortest_job_first_selector RTL.
module tb import sjf_pkg::*; ();

  localparam int DEPTH       = SJF_TABLE_DEPTH;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 3 * DEPTH + 10;
  localparam int PHASES      = 35;
  localparam int PHASE_ITEMS = 50;
  localparam int MAX_GAP     = 13;

  // Burst profiles for the random phases.
  typedef enum int {
    BURST_NARROW,
    BURST_FULL,
    BURST_EDGES
  } burst_profile_t;

  // Tracks the task table and the responses that are still owed.
  class sjf_schedule_tracker;
    bit                 slot_live [DEPTH];
    logic [ID_W-1:0]    slot_id   [DEPTH];
    logic [PRIO_W-1:0]  slot_prio [DEPTH];
    logic [BURST_W-1:0] slot_burst[DEPTH];
    int                 slot_age  [DEPTH];
    logic [ID_W-1:0]    id_counter;
    sjf_result_t        owed_results[$];
    int                 errors;

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      id_counter = FIRST_ID;
      errors = 0;
    endfunction

    // Lowest free slot takes the task; everything stored grows one step older.
    function void predict_add(logic [PRIO_W-1:0] pr, logic [BURST_W-1:0] bu);
      int free_slot;
      sjf_result_t res;
      free_slot = -1;
      res = '0;
      for (int i = 0; i < DEPTH; i++)
        if (!slot_live[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) begin
        res.status = ST_FULL;
      end else begin
        for (int i = 0; i < DEPTH; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_live[free_slot]  = 1'b1;
        slot_id[free_slot]    = id_counter;
        slot_prio[free_slot]  = pr;
        slot_burst[free_slot] = bu;
        slot_age[free_slot]   = 0;
        res.status  = ST_ADDED;
        res.task_id = id_counter;
        id_counter  = (id_counter == '1) ? FIRST_ID : id_counter + 1'b1;
      end
      owed_results.push_back(res);
    endfunction

    // Smallest burst wins, the newest task breaks a tie; the winner leaves the table.
    function void predict_dispatch();
      int pick;
      sjf_result_t res;
      pick = -1;
      res = '0;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_live[i] && (pick < 0 || slot_burst[i] < slot_burst[pick] ||
            (slot_burst[i] == slot_burst[pick] && slot_age[i] < slot_age[pick])))
          pick = i;
      end
      if (pick < 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.status  = ST_DISPATCHED;
        res.task_id = slot_id[pick];
        res.prio    = slot_prio[pick];
        res.burst   = slot_burst[pick];
        slot_live[pick] = 1'b0;
        for (int i = 0; i < DEPTH; i++)
          if (slot_live[i] && slot_age[i] > slot_age[pick]) slot_age[i]--;
      end
      owed_results.push_back(res);
    endfunction

    function void note_request(logic op, logic [PRIO_W-1:0] pr, logic [BURST_W-1:0] bu);
      if (op == OP_ADD) predict_add(pr, bu);
      else predict_dispatch();
    endfunction

    function void report_field(string field, int unsigned want, int unsigned got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_response(sjf_result_t seen);
      sjf_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: response with none owed, expected nothing, actual %0d/%0d/%0d/%0d",
                 $time, seen.status, seen.task_id, seen.prio, seen.burst);
        return;
      end
      want = owed_results.pop_front();
      report_field("status", want.status, seen.status);
      report_field("task id", want.task_id, seen.task_id);
      report_field("priority", want.prio, seen.prio);
      report_field("burst", want.burst, seen.burst);
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   sender_idle;
  bit   receiver_idle;
  int   quiet_cycles;

  sjf_req_if req_ch ();
  sjf_rsp_if rsp_ch ();

  sjf_schedule_tracker tracker = new();

  shortest_job_first_selector #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Clock with a period of 20.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Record every transaction on both channels; responses are checked first.
  always @(posedge clk) begin : monitor
    sjf_result_t seen;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.status  = status_t'(rsp_ch.status);
        seen.task_id = rsp_ch.out_task_id;
        seen.prio    = rsp_ch.out_priority;
        seen.burst   = rsp_ch.out_burst;
        tracker.check_response(seen);
      end
      if (req_ch.valid && req_ch.ready)
        tracker.note_request(req_ch.opcode, req_ch.task_priority, req_ch.task_burst);
    end
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side: when receiver_idle is set, stall a random number of cycles before taking each transaction.
  initial begin : receiver
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Offer one request transaction, after a random gap when sender_idle is set, and wait until it is taken.
  task automatic send_request(logic op, logic [PRIO_W-1:0] pr, logic [BURST_W-1:0] bu);
    int gap;
    gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.task_priority <= pr;
    req_ch.task_burst    <= bu;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every owed response has come back.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed() != 0) @(posedge clk);
  endtask

  function automatic logic [BURST_W-1:0] pick_burst(burst_profile_t profile);
    case (profile)
      BURST_NARROW: return BURST_W'($urandom_range(0, 7));
      BURST_EDGES: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return BURST_W'($urandom_range(1, 3));
          default: return BURST_W'($urandom_range(65532, 65534));
        endcase
      end
      default: return BURST_W'($urandom);
    endcase
  endfunction

  // Stimulus: directed corner cases, then random phases.
  initial begin : stimulus
    int add_pct;
    burst_profile_t profile;
    logic [PRIO_W-1:0] pr;
    logic [BURST_W-1:0] bu;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_ADD;
    req_ch.task_priority <= '0;
    req_ch.task_burst    <= '0;
    rst <= 1'b1;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Dispatch from an empty table.
    send_request(OP_DISPATCH, '1, '1);

    // Fill the table, with zero and maximum bursts and a three-way tie, then overflow it.
    for (int i = 0; i <= DEPTH; i++) begin
      case (i)
        0: begin pr = '0; bu = '0; end
        1: begin pr = '1; bu = '1; end
        2, 3, 4: begin pr = PRIO_W'(i); bu = 16'd100; end
        default: begin pr = PRIO_W'($urandom); bu = BURST_W'($urandom_range(200, 65534)); end
      endcase
      send_request(OP_ADD, pr, bu);
    end

    // Take out the zero burst, the tied tasks newest first, and one more task.
    repeat (5) send_request(OP_DISPATCH, PRIO_W'($urandom), BURST_W'($urandom));
    hold_until_drained();

    // Random phases, each with its own add share, burst profile and idling.
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 4))
        0: add_pct = 90;
        1: add_pct = 70;
        2: add_pct = 50;
        3: add_pct = 30;
        default: add_pct = 10;
      endcase
      profile = burst_profile_t'($urandom_range(0, 2));
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(1, 100) <= add_pct)
          send_request(OP_ADD, PRIO_W'($urandom), pick_burst(profile));
        else
          send_request(OP_DISPATCH, PRIO_W'($urandom), BURST_W'($urandom));
      end
      if (p == 0 || $urandom_range(0, 3) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
